// ===== hw/rtl/sobel_gradient_magnitude_defines.svh =====
// Assertion macros shared by the Sobel block.
`ifndef SOBEL_GRADIENT_MAGNITUDE_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define SGM_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sobel gradient check failed");

// Next-cycle implication, off during reset.
`define SGM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sobel gradient sequencing check failed");

`endif

// ===== hw/rtl/sgm_pkg.sv =====
package sgm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int PIX_W          = 8;
  localparam int CFG_W          = 11;
  localparam int ROOT_STEPS     = 8;

  // register select (paddr[2])
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // result kinds of one input beat; bit 0 = lower row mirrored, bit 1 = edge column
  localparam logic [1:0] KIND_INNER     = 2'd0;
  localparam logic [1:0] KIND_LOW_ROW   = 2'd1;
  localparam logic [1:0] KIND_EDGE_COL  = 2'd2;
  localparam logic [1:0] KIND_CORNER    = 2'd3;

  typedef logic [2:0][PIX_W-1:0] pix3_t;

  typedef struct packed {
    logic        vld;
    logic        sat;
    logic [15:0] s;
    logic [7:0]  root;
  } sqrt_stage_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GRAD,
    ST_SUM,
    ST_LAUNCH,
    ST_ROOT,
    ST_OUT
  } sgm_state_t;

endpackage

// ===== hw/rtl/sgm_line_store.sv =====
module sgm_line_store import sgm_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEF_MAX_WIDTH)
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [2*PIX_W-1:0]   rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [2*PIX_W-1:0]   wr_data
);

  // word = {upper line, lower line}
  logic [2*PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/sgm_col_cell.sv =====
module sgm_col_cell import sgm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  pix3_t d,
  output pix3_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== hw/rtl/sgm_sqrt_cell.sv =====
module sgm_sqrt_cell import sgm_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  sqrt_stage_t d,
  output sqrt_stage_t q
);

  localparam logic [7:0] TRIAL_BIT = 8'(1 << (ROOT_STEPS - 1 - STEP));

  logic [7:0]  trial;
  logic [15:0] trial_sq;

  assign trial    = d.root | TRIAL_BIT;
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    q.sat  <= d.sat;
    q.s    <= d.s;
    q.root <= (trial_sq <= d.s) ? trial : d.root;
    if (rst) begin
      q.vld <= 1'b0;
    end else begin
      q.vld <= d.vld;
    end
  end

endmodule

// ===== hw/rtl/sobel_gradient_magnitude.sv =====
// Sobel 3x3 edge magnitude over a raster stream of 8-bit pixels. Each input beat
// passes a line store read, then a window shift and store write, and each result
// it causes passes the square stage, the sum stage and an eight-cell square-root
// chain that settles one root bit per cell. A pixel in the first row or column gives
// no result; the final pixel of a frame gives four results. No new pixel is taken
// until every result of the last one is in the output register, and the next pixel
// is taken while the last result still waits at the output. Borders mirror without
// repeating the edge pixel; magnitudes above 255 saturate. Writing either size
// register restarts the frame.
`include "sobel_gradient_magnitude_defines.svh"

module sobel_gradient_magnitude import sgm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] magnitude
  output logic        m_tlast,   // frame_end
  output logic        m_tuser,   // [0] run_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW = CW + 1;
  localparam int HW = RW + 1;

  // configuration
  logic [CFG_W-1:0] cfg_w, cfg_h;
  logic             cfg_wr;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_IMAGE_HEIGHT) ? 32'(cfg_h) : 32'(cfg_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= CFG_W'(1024);
      cfg_h <= CFG_W'(1024);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_IMAGE_WIDTH) begin
        cfg_w <= pwdata[CFG_W-1:0];
      end else begin
        cfg_h <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_w < CFG_W'(2)) w_eff = WW'(2);
    else if (32'(cfg_w) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_w);
    if (cfg_h < CFG_W'(2)) h_eff = HW'(2);
    else if (32'(cfg_h) > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(cfg_h);
  end

  // control
  sgm_state_t    state, state_next;
  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic [7:0]    px;
  logic [3:0]    mask, mask_next;
  logic [1:0]    kind, kind_next;
  logic          r_first, c_first;
  logic          mem_rd, mem_wr, win_shift, launch, out_load, more;
  logic [2*PIX_W-1:0] rd_word;

  // kinds still due after the current one
  logic [3:0] later;
  always_comb begin
    later = mask;
    for (int i = 0; i < 4; i++) begin
      if (i <= int'(kind)) later[i] = 1'b0;
    end
  end
  assign more = |later;

  logic [1:0] first_kind, after_kind;
  logic [3:0] new_mask;
  logic       gate, last_row, last_col;

  assign gate     = (row != '0) && (col != '0);
  assign last_row = ({1'b0, row} == h_eff - HW'(1));
  assign last_col = ({1'b0, col} == w_eff - WW'(1));
  assign new_mask = {gate && last_row && last_col, gate && last_col,
                     gate && last_row, gate};

  always_comb begin
    first_kind = KIND_INNER;
    after_kind = KIND_INNER;
    for (int i = 3; i >= 0; i--) begin
      if (new_mask[i]) first_kind = 2'(i);
      if (later[i]) after_kind = 2'(i);
    end
  end

  // square-root chain
  sqrt_stage_t stg [ROOT_STEPS+1];
  logic [20:0] sum;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_rd     = 1'b0;
    mem_wr     = 1'b0;
    win_shift  = 1'b0;
    launch     = 1'b0;
    out_load   = 1'b0;
    mask_next  = mask;
    kind_next  = kind;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          mem_rd     = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        mem_wr    = 1'b1;
        win_shift = 1'b1;
        mask_next = new_mask;
        kind_next = first_kind;
        state_next = gate ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_LAUNCH;
      ST_LAUNCH: begin
        launch     = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (stg[ROOT_STEPS].vld) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          if (more) begin
            kind_next  = after_kind;
            state_next = ST_GRAD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      col   <= '0;
      row   <= '0;
      mask  <= '0;
      kind  <= KIND_INNER;
    end else begin
      state <= state_next;
      mask  <= mask_next;
      kind  <= kind_next;
      if (cfg_wr) begin
        col <= '0;
        row <= '0;
      end else begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_comb begin
    col_next = col;
    row_next = row;
    if (state == ST_READ) begin
      if (last_col) begin
        col_next = '0;
        row_next = last_row ? '0 : row + RW'(1);
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) px <= s_tdata;
    if (state == ST_READ) begin
      r_first <= (row == RW'(1));
      c_first <= (col == CW'(1));
    end
  end

  sgm_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_lines (
    .clk     (clk),
    .rd_en   (mem_rd),
    .rd_addr (col),
    .rd_data (rd_word),
    .wr_en   (mem_wr),
    .wr_addr (col),
    .wr_data ({rd_word[PIX_W-1:0], px})
  );

  // window: three column cells, newest column on the right
  pix3_t col_in, win_l, win_c, win_r;
  assign col_in = {px, rd_word[PIX_W-1:0], rd_word[2*PIX_W-1:PIX_W]};

  sgm_col_cell u_cell_r (.clk(clk), .rst(rst), .shift(win_shift), .d(col_in), .q(win_r));
  sgm_col_cell u_cell_c (.clk(clk), .rst(rst), .shift(win_shift), .d(win_r),  .q(win_c));
  sgm_col_cell u_cell_l (.clk(clk), .rst(rst), .shift(win_shift), .d(win_c),  .q(win_l));

  // mirrored neighbourhood for the current kind
  logic          low_sel, edge_sel;
  logic [7:0]    t0, t1, t2, m0, m2, b0, b1, b2;
  logic [2:0][7:0] row_t, row_m, row_b, cols0, cols1, cols2;

  assign low_sel  = kind[0];
  assign edge_sel = kind[1];
  assign cols0 = edge_sel ? win_c : (c_first ? win_r : win_l);
  assign cols1 = edge_sel ? win_r : win_c;
  assign cols2 = edge_sel ? win_c : win_r;
  assign row_t = low_sel ? {cols2[1], cols1[1], cols0[1]}
               : (r_first ? {cols2[2], cols1[2], cols0[2]} : {cols2[0], cols1[0], cols0[0]});
  assign row_m = low_sel ? {cols2[2], cols1[2], cols0[2]} : {cols2[1], cols1[1], cols0[1]};
  assign row_b = low_sel ? {cols2[1], cols1[1], cols0[1]} : {cols2[2], cols1[2], cols0[2]};
  assign t0 = row_t[0];
  assign t1 = row_t[1];
  assign t2 = row_t[2];
  assign m0 = row_m[0];
  assign m2 = row_m[2];
  assign b0 = row_b[0];
  assign b1 = row_b[1];
  assign b2 = row_b[2];

  logic signed [11:0] gx, gy;
  logic signed [23:0] gx2, gy2;
  logic [19:0]        sx, sy;

  assign gx = ($signed({4'b0, t2}) - $signed({4'b0, t0}))
            + (($signed({4'b0, m2}) - $signed({4'b0, m0})) <<< 1)
            + ($signed({4'b0, b2}) - $signed({4'b0, b0}));
  assign gy = ($signed({4'b0, b0}) + ($signed({4'b0, b1}) <<< 1) + $signed({4'b0, b2}))
            - ($signed({4'b0, t0}) + ($signed({4'b0, t1}) <<< 1) + $signed({4'b0, t2}));
  assign gx2 = gx * gx;
  assign gy2 = gy * gy;

  always_ff @(posedge clk) begin
    if (state == ST_GRAD) begin
      sx <= gx2[19:0];
      sy <= gy2[19:0];
    end
    if (state == ST_SUM) sum <= 21'(sx) + 21'(sy);
  end

  assign stg[0].vld  = launch;
  assign stg[0].sat  = |sum[20:16];
  assign stg[0].s    = sum[15:0];
  assign stg[0].root = '0;

  for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
    sgm_sqrt_cell #(.STEP(g)) u_sqrt (
      .clk (clk),
      .rst (rst),
      .d   (stg[g]),
      .q   (stg[g+1])
    );
  end

  logic [7:0] mag;
  always_ff @(posedge clk) begin
    if (state == ST_ROOT && stg[ROOT_STEPS].vld) begin
      mag <= stg[ROOT_STEPS].sat ? 8'hFF : stg[ROOT_STEPS].root;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= mag;
      m_tuser <= !more;
      m_tlast <= (kind == KIND_CORNER);
    end
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  logic [15:0] root_sq;
  assign root_sq = stg[ROOT_STEPS].root * stg[ROOT_STEPS].root;

  `SGM_ASSERT_NEXT(a_accept_reads, s_tvalid && s_tready, state == ST_READ)
  `SGM_ASSERT_HOLDS(a_end_is_run_last, m_tvalid && m_tlast, m_tuser)
  `SGM_ASSERT_HOLDS(a_col_in_range, 1'b1, 32'(col) < 32'(w_eff))
  `SGM_ASSERT_HOLDS(a_root_bound, stg[ROOT_STEPS].vld && !stg[ROOT_STEPS].sat, root_sq <= stg[ROOT_STEPS].s)
  `SGM_ASSERT_HOLDS(a_chain_owned, stg[ROOT_STEPS].vld, state == ST_ROOT)

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import sgm_pkg::*;

  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] magnitude;
    logic       run_last;
    logic       frame_end;
  } sobel_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sobel_gradient_magnitude uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [7:0]    upper_line [MAXW];
  logic [7:0]    lower_line [MAXW];
  logic [7:0]    win [9];
  int unsigned   col_pos, row_pos;
  logic [10:0]   width_reg, height_reg;
  sobel_result_t magnitudes_due [$];

  int  errors;
  int  quiet_cycles;
  bit  sink_idle_en;
  bit  src_idle_en;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] root_sat(int unsigned s);
    logic [7:0] root;
    logic [7:0] t;
    root = 0;
    if (s >= 65536) return 8'd255;
    for (int b = 7; b >= 0; b--) begin
      t = root | (8'd1 << b);
      if (int'(t) * int'(t) <= s) root = t;
    end
    return root;
  endfunction

  function automatic logic [7:0] grad_mag(int r0, int r1, int r2, int c0, int c1, int c2);
    int rs [3];
    int cs [3];
    int gx, gy;
    rs = '{r0, r1, r2};
    cs = '{c0, c1, c2};
    gx = (int'(win[rs[0]*3+cs[2]]) - int'(win[rs[0]*3+cs[0]]))
       + 2 * (int'(win[rs[1]*3+cs[2]]) - int'(win[rs[1]*3+cs[0]]))
       + (int'(win[rs[2]*3+cs[2]]) - int'(win[rs[2]*3+cs[0]]));
    gy = (int'(win[rs[2]*3+cs[0]]) + 2 * int'(win[rs[2]*3+cs[1]]) + int'(win[rs[2]*3+cs[2]]))
       - (int'(win[rs[0]*3+cs[0]]) + 2 * int'(win[rs[0]*3+cs[1]]) + int'(win[rs[0]*3+cs[2]]));
    return root_sat(gx * gx + gy * gy);
  endfunction

  task automatic predict_pixel(logic [7:0] px);
    int unsigned w, h, c, r;
    int n0, ru;
    bit last_row, last_col;
    sobel_result_t res;
    w = clamp_dim(width_reg, MAXW);
    h = clamp_dim(height_reg, MAXH);
    c = col_pos;
    r = row_pos;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = upper_line[c];
    win[5] = lower_line[c];
    win[8] = px;
    upper_line[c] = lower_line[c];
    lower_line[c] = px;
    if (r >= 1 && c >= 1) begin
      last_row = (r == h - 1);
      last_col = (c == w - 1);
      ru = (r == 1) ? 2 : 0;
      n0 = (c == 1) ? 2 : 0;
      res = '{grad_mag(ru, 1, 2, n0, 1, 2), 1'b0, 1'b0};
      magnitudes_due.push_back(res);
      if (last_row) begin
        res = '{grad_mag(1, 2, 1, n0, 1, 2), 1'b0, 1'b0};
        magnitudes_due.push_back(res);
      end
      if (last_col) begin
        res = '{grad_mag(ru, 1, 2, 1, 2, 1), 1'b0, 1'b0};
        magnitudes_due.push_back(res);
        if (last_row) begin
          res = '{grad_mag(1, 2, 1, 1, 2, 1), 1'b0, 1'b1};
          magnitudes_due.push_back(res);
        end
      end
      magnitudes_due[$].run_last = 1'b1;
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // result checker and sink stall
  always @(posedge clk) begin
    sobel_result_t got, want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (m_tvalid && m_tready) begin
        got = '{m_tdata, m_tuser, m_tlast};
        if (magnitudes_due.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          errors++;
        end else begin
          want = magnitudes_due.pop_front();
          if (got.magnitude !== want.magnitude)
            $display("%0t: magnitude expected %0d actual %0d", $time,
                     want.magnitude, got.magnitude);
          if (got.run_last !== want.run_last)
            $display("%0t: run_last expected %0b actual %0b", $time,
                     want.run_last, got.run_last);
          if (got.frame_end !== want.frame_end)
            $display("%0t: frame_end expected %0b actual %0b", $time,
                     want.frame_end, got.frame_end);
          if (got !== want) errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !sink_idle_en || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if (!rst && quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // tvalid stays high after the beat; a pause in the next send or a drain drops it
  task automatic send_pixel(logic [7:0] px);
    while (src_idle_en && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_pixel(px);
    @(negedge clk);
  endtask

  task automatic drain_results;
    s_tvalid <= 1'b0;
    while (magnitudes_due.size() != 0) @(negedge clk);
    // a pixel with no result may still be in flight
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr[2] == REG_IMAGE_WIDTH) width_reg = val[10:0];
    else height_reg = val[10:0];
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    drain_results();
    write_reg({REG_IMAGE_WIDTH, 2'b00}, w);
    write_reg({REG_IMAGE_HEIGHT, 2'b00}, h);
  endtask

  // full frame, pixel chosen by kind: 0 random, 1 zero, 2 full, 3 chequer
  task automatic send_frame(int unsigned w, int unsigned h, int kind);
    logic [7:0] px;
    for (int unsigned r = 0; r < h; r++)
      for (int unsigned c = 0; c < w; c++) begin
        case (kind)
          1: px = 8'h00;
          2: px = 8'hff;
          3: px = ((r + c) % 2) ? 8'hff : 8'h00;
          default: px = $urandom_range(255);
        endcase
        send_pixel(px);
      end
  endtask

  task automatic test_directed;
    set_size(2, 2);
    send_frame(2, 2, 1);
    send_frame(2, 2, 2);
    send_frame(2, 2, 3);
    set_size(3, 3);
    send_frame(3, 3, 3);
    // chequer frame sent pixel by pixel: every gradient cancels to zero
    send_pixel(8'hff); send_pixel(8'h00); send_pixel(8'hff);
    send_pixel(8'h00); send_pixel(8'hff); send_pixel(8'h00);
    send_pixel(8'hff); send_pixel(8'h00); send_pixel(8'hff);
  endtask

  task automatic test_out_of_range_sizes;
    set_size(0, 1);          // clamps to 2x2
    send_frame(2, 2, 0);
    set_size(2047, 3);       // width clamps to maximum; partial row then restart
    repeat (5) send_pixel($urandom_range(255));
    set_size(4, 2047);
    repeat (6) send_pixel($urandom_range(255));
  endtask

  task automatic test_random_frames(int target);
    int unsigned w, h;
    int sent;
    sent = 0;
    while (sent < target) begin
      w = $urandom_range(2, 9);
      h = $urandom_range(2, 6);
      set_size(w, h);
      repeat ($urandom_range(1, 2)) begin
        send_frame(w, h, 0);
        sent += w * h;
      end
      if (($urandom_range(3)) == 0) begin
        // pause until every predicted result has drained, then a stray run of up to two rows
        s_tvalid <= 1'b0;
        while (magnitudes_due.size() != 0) @(negedge clk);
        repeat ($urandom_range(1, 2 * w)) send_pixel($urandom_range(255));
        sent += 1;
      end
    end
  endtask

  task automatic test_wide_frame;
    set_size(64, 2);
    sink_idle_en = 1'b0;
    src_idle_en = 1'b0;
    send_frame(64, 2, 0);
    sink_idle_en = 1'b1;
    src_idle_en = 1'b1;
  endtask

  initial begin
    errors = 0;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = 8'h00;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 3'd0; pwdata = 32'd0;
    sink_idle_en = 1'b1;
    src_idle_en = 1'b1;
    width_reg = 11'd1024;
    height_reg = 11'd1024;
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < 9; i++) win[i] = 8'h00;
    for (int i = 0; i < MAXW; i++) begin
      upper_line[i] = 8'h00;
      lower_line[i] = 8'h00;
    end
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_out_of_range_sizes();
    test_random_frames(50);
    test_wide_frame();
    test_random_frames(50);

    drain_results();
    if (errors == 0 && magnitudes_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sobel_gradient_magnitude.f =====
+incdir+hw/rtl
hw/rtl/sgm_pkg.sv
hw/rtl/sgm_line_store.sv
hw/rtl/sgm_col_cell.sv
hw/rtl/sgm_sqrt_cell.sv
hw/rtl/sobel_gradient_magnitude.sv
sim/testbench.sv
